[rtl/core/ihb_pkg.sv]
// Shared types and constants for the IPv4 header builder.
package ihb_pkg;

	localparam int unsigned HdrWords = 10;
	localparam int unsigned IdxW = 4;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(HdrWords - 1);

	localparam logic [15:0] WordVerIhl = 16'h4500;
	localparam logic [15:0] WordIdent = 16'h0001;
	localparam logic [15:0] WordFlags = 16'h4000;
	localparam logic [7:0] TtlDefault = 8'h40;
	localparam logic [16:0] HdrBytes = 17'd20;
	localparam logic [15:0] TotalMax = 16'hFFFF;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] RegLocalAddr = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSubnetMask = 2'd1;
	localparam logic [CfgIdxW-1:0] RegGatewayAddr = 2'd2;

	typedef struct packed {
		logic [31:0] destination_address;
		logic [7:0] protocol_number;
		logic [15:0] payload_bytes;
	} in_item_t;

	typedef struct packed {
		logic [15:0] header_word;
		logic [3:0] word_index;
		logic last_word;
		logic [31:0] next_hop;
	} out_item_t;

	typedef struct packed {
		logic [HdrWords-1:0][15:0] words;
		logic [31:0] next_hop;
	} hdr_t;

endpackage

[rtl/core/ihb_serializer.sv]
// Holds one finished header and sends its ten words into the output register.
module ihb_serializer (
	input logic clk,
	input logic arst_n,
	input logic load,
	input ihb_pkg::hdr_t hdr,
	output logic free,
	output logic out_valid,
	input logic out_stall,
	output ihb_pkg::out_item_t out_item
);
	import ihb_pkg::*;

	logic ser_valid_q;
	logic [IdxW-1:0] idx_q;
	hdr_t hdr_q;
	logic out_valid_q;
	out_item_t out_q;

	logic out_free;
	logic ser_emit;
	logic ser_done;

	assign out_free = !out_valid_q || !out_stall;
	assign ser_emit = ser_valid_q && out_free;
	assign ser_done = ser_emit && (idx_q == LastIdx);
	assign free = !ser_valid_q || ser_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				ser_valid_q <= 1'b1;
				idx_q <= '0;
			end else if (ser_emit) begin
				idx_q <= idx_q + 1'b1;
				if (ser_done) begin
					ser_valid_q <= 1'b0;
				end
			end
			if (ser_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_q <= hdr;
		end
		if (ser_emit) begin
			out_q.header_word <= hdr_q.words[idx_q];
			out_q.word_index <= idx_q;
			out_q.last_word <= (idx_q == LastIdx);
			out_q.next_hop <= hdr_q.next_hop;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid_q |-> (idx_q <= LastIdx))
		else $error("word counter past last header word");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last_word == (out_q.word_index == LastIdx)))
		else $error("last_word does not match word_index");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !out_q.last_word) |=>
			(out_valid_q && (out_q.word_index == $past(out_q.word_index) + 1'b1)))
		else $error("header words not sent back to back in order");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("header loaded while previous one still being sent");

endmodule

[rtl/core/ipv4_header_builder.sv]
// Top level of the IPv4 header builder: config, input stages and header assembly.
//
// Usage:
//   Each accepted input item (destination, protocol, payload length) turns into
//   ten output items, the 16-bit header words 0..9 in wire order, each tagged
//   with word_index, last_word on word 9, and the next hop (gateway when the
//   destination lies outside the local subnet, the destination otherwise).
//   Channels use valid/stall: an item moves on a clock edge with valid high
//   and stall low. Configuration is a plain write port (cfg_we, cfg_index,
//   cfg_data); index 0 local address, 1 subnet mask, 2 gateway; other indexes
//   are dropped. Write it only while the block is idle.
// Timing:
//   Word 0 of an item passes the input register, sum register and serializer into
//   the 16-bit output register; the words then follow one per cycle while the output
//   does not stall. Items are accepted while a header is being sent: two further
//   items can queue up in the input and sum registers behind the serializer.
// Reset and stall:
//   Reset clears the configuration registers and every valid flag, so each
//   stage starts empty; data registers are don't-care until loaded. A stall on
//   the output holds the current word; the serializer then backs up and the
//   input stall rises once both front stages are full.
module ipv4_header_builder (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ihb_pkg::CfgIdxW-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input ihb_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output ihb_pkg::out_item_t out_item
);
	import ihb_pkg::*;

	// configuration registers
	logic [31:0] local_addr_q;
	logic [31:0] subnet_mask_q;
	logic [31:0] gateway_addr_q;

	// stage 1: captured request
	logic valid_s1;
	in_item_t item_s1;

	// stage 2: total length, raw checksum sum and next hop
	logic valid_s2;
	logic [31:0] dst_s2;
	logic [7:0] proto_s2;
	logic [15:0] total_s2;
	logic [19:0] sum_s2;
	logic [31:0] hop_s2;

	logic ser_free;
	logic s2_move;
	logic s2_free;
	logic s1_move;
	logic s1_free;

	logic [16:0] total_raw;
	logic [15:0] total_sat;
	logic [19:0] sum_raw;
	logic [31:0] hop_sel;
	logic [16:0] fold1;
	logic [15:0] fold2;
	hdr_t hdr;

	// Handshake chain: a stage moves when the one after it is empty or moving.
	assign s2_move = valid_s2 && ser_free;
	assign s2_free = !valid_s2 || s2_move;
	assign s1_move = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || s1_move;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			subnet_mask_q <= '0;
			gateway_addr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLocalAddr: local_addr_q <= cfg_data;
				RegSubnetMask: subnet_mask_q <= cfg_data;
				RegGatewayAddr: gateway_addr_q <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Total length saturates when the payload would push it past 16 bits.
	assign total_raw = {1'b0, item_s1.payload_bytes} + HdrBytes;
	assign total_sat = total_raw[16] ? TotalMax : total_raw[15:0];

	// Sum of the nine header words other than the checksum; nine 16-bit terms fit in 20 bits.
	assign sum_raw = 20'(WordVerIhl) + 20'(WordIdent) + 20'(WordFlags)
		+ 20'({TtlDefault, item_s1.protocol_number}) + 20'(total_sat)
		+ 20'(local_addr_q[31:16]) + 20'(local_addr_q[15:0])
		+ 20'(item_s1.destination_address[31:16])
		+ 20'(item_s1.destination_address[15:0]);

	assign hop_sel = ((item_s1.destination_address & subnet_mask_q)
		!= (local_addr_q & subnet_mask_q)) ? gateway_addr_q : item_s1.destination_address;

	always_ff @(posedge clk) begin
		if (s1_free) begin
			item_s1 <= in_item;
		end
		if (s1_move) begin
			dst_s2 <= item_s1.destination_address;
			proto_s2 <= item_s1.protocol_number;
			total_s2 <= total_sat;
			sum_s2 <= sum_raw;
			hop_s2 <= hop_sel;
		end
	end

	// End-around carry: two folds bring a 20-bit sum down to 16 bits.
	assign fold1 = {1'b0, sum_s2[15:0]} + {13'b0, sum_s2[19:16]};
	assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

	always_comb begin
		hdr.words[0] = WordVerIhl;
		hdr.words[1] = total_s2;
		hdr.words[2] = WordIdent;
		hdr.words[3] = WordFlags;
		hdr.words[4] = {TtlDefault, proto_s2};
		hdr.words[5] = ~fold2;
		hdr.words[6] = local_addr_q[31:16];
		hdr.words[7] = local_addr_q[15:0];
		hdr.words[8] = dst_s2[31:16];
		hdr.words[9] = dst_s2[15:0];
		hdr.next_hop = hop_s2;
	end

	ihb_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.load(s2_move),
		.hdr(hdr),
		.free(ser_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 item changed while blocked");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !s2_move) |=> (valid_s2 && $stable(sum_s2) && $stable(hop_s2)))
		else $error("stage 2 item changed while blocked");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free front stage");

endmodule

[tb/sv/ihb_header_checker.sv]
// Checker for the IPv4 header builder: predicts the ten header words of each item and compares.
module ihb_header_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ihb_pkg::CfgIdxW-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input ihb_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input ihb_pkg::out_item_t out_item,
	output int unsigned mismatch_count,
	output int unsigned words_pending,
	output int unsigned words_checked
);
	import ihb_pkg::*;

	localparam int unsigned ReportMax = 10;

	logic [31:0] own_addr;
	logic [31:0] net_mask;
	logic [31:0] gw_addr;
	out_item_t header_fifo[$];

	// build the header for one request and queue its ten words
	function automatic void predict_header(input in_item_t req);
		logic [15:0] w [HdrWords];
		logic [16:0] total;
		logic [31:0] sum;
		logic [31:0] hop;
		out_item_t word;
		total = {1'b0, req.payload_bytes} + 17'd20;
		if (total > 17'h0FFFF)
			total = 17'h0FFFF;
		w[0] = 16'h4500;
		w[1] = total[15:0];
		w[2] = 16'h0001;
		w[3] = 16'h4000;
		w[4] = {8'h40, req.protocol_number};
		w[5] = 16'h0000;
		w[6] = own_addr[31:16];
		w[7] = own_addr[15:0];
		w[8] = req.destination_address[31:16];
		w[9] = req.destination_address[15:0];
		sum = 32'h0;
		for (int k = 0; k < HdrWords; k++)
			sum = sum + {16'h0, w[k]};
		while (sum[31:16] != 16'h0)
			sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
		w[5] = ~sum[15:0];
		if ((req.destination_address & net_mask) != (own_addr & net_mask))
			hop = gw_addr;
		else
			hop = req.destination_address;
		for (int k = 0; k < HdrWords; k++) begin
			word.header_word = w[k];
			word.word_index = 4'(k);
			word.last_word = (k == HdrWords - 1);
			word.next_hop = hop;
			header_fifo.push_back(word);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			own_addr = 32'h0;
			net_mask = 32'h0;
			gw_addr = 32'h0;
			header_fifo.delete();
			mismatch_count = 0;
			words_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (header_fifo.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= ReportMax)
						$display("unexpected header word: word %h idx %0d last %b hop %h",
							out_item.header_word, out_item.word_index,
							out_item.last_word, out_item.next_hop);
				end else begin
					want = header_fifo.pop_front();
					words_checked++;
					if (out_item.header_word !== want.header_word ||
							out_item.word_index !== want.word_index ||
							out_item.last_word !== want.last_word ||
							out_item.next_hop !== want.next_hop) begin
						mismatch_count++;
						if (mismatch_count <= ReportMax) begin
							$display("header word %0d: expected word %h idx %0d last %b hop %h,",
								want.word_index, want.header_word, want.word_index,
								want.last_word, want.next_hop);
							$display("  got word %h idx %0d last %b hop %h",
								out_item.header_word, out_item.word_index,
								out_item.last_word, out_item.next_hop);
						end
					end
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					RegLocalAddr: own_addr = cfg_data;
					RegSubnetMask: net_mask = cfg_data;
					RegGatewayAddr: gw_addr = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_header(in_item);
		end
		words_pending = header_fifo.size();
	end

endmodule

[tb/sv/ipv4_header_builder_tb.sv]
// Testbench top for the IPv4 header builder: stimulus, idling, watchdog and verdict.
module ipv4_header_builder_tb;
	import ihb_pkg::*;

	// index that maps to no register; writes to it must be dropped
	localparam logic [CfgIdxW-1:0] RegNone = 2'd3;
	// no handshake for this many cycles means the block is hung
	localparam int unsigned QuietLimit = 2000;
	// cycles to let the pipeline settle after the last word
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned RandomPhases = 5;
	localparam int unsigned PhaseItems = 80;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	int unsigned mismatch_count;
	int unsigned words_pending;
	int unsigned words_checked;

	// stimulus-side copy of address and mask, used to aim destinations
	logic [31:0] own_addr;
	logic [31:0] net_mask;
	logic idle_on;
	int unsigned requests_sent;
	int unsigned settings_used;
	int unsigned quiet_cycles;

	ipv4_header_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	ihb_header_checker header_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.mismatch_count(mismatch_count),
		.words_pending(words_pending),
		.words_checked(words_checked)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Write one register at the next falling edge; hold the enable for one cycle.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		unique case (idx)
			RegLocalAddr: own_addr = value;
			RegSubnetMask: net_mask = value;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [31:0] local_addr, input logic [31:0] mask,
			input logic [31:0] gateway);
		write_reg(RegLocalAddr, local_addr);
		write_reg(RegSubnetMask, mask);
		write_reg(RegGatewayAddr, gateway);
		settings_used++;
	endtask

	// Random setting: mostly contiguous prefixes, sometimes a ragged mask,
	// sometimes a stray write to the unused index.
	task automatic random_setting();
		logic [31:0] mask;
		int unsigned prefix;
		prefix = $urandom_range(0, 32);
		if ($urandom_range(0, 4) == 0)
			mask = $urandom;
		else if (prefix == 0)
			mask = 32'h0;
		else
			mask = 32'hFFFF_FFFF << (32 - prefix);
		apply_setting($urandom, mask, $urandom);
		if ($urandom_range(0, 2) == 0)
			write_reg(RegNone, $urandom);
	endtask

	// Present one request from a falling edge, possibly after an idle burst, and
	// hold it until the block takes it. Return at the falling edge after acceptance.
	task automatic send_request(input in_item_t req);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_item = req;
		do
			@(posedge clk);
		while (in_stall);
		requests_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every queued word, then let the pipeline settle.
	task automatic drain();
		in_valid = 1'b0;
		wait (words_pending == 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// Pick a low destination half so that the folded header sum comes to all ones,
	// which forces a checksum word of zero.
	function automatic logic [31:0] zero_cksum_dst(input logic [15:0] dst_hi,
			input logic [7:0] proto, input logic [15:0] pay);
		logic [16:0] total;
		logic [31:0] acc;
		total = {1'b0, pay} + 17'd20;
		if (total[16])
			total = 17'h0FFFF;
		acc = 32'h4500 + {15'h0, total} + 32'h0001 + 32'h4000 + {16'h0, 8'h40, proto}
			+ {16'h0, own_addr[31:16]} + {16'h0, own_addr[15:0]} + {16'h0, dst_hi};
		while (acc[31:16] != 16'h0)
			acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
		return {dst_hi, 16'hFFFF - acc[15:0]};
	endfunction

	// Random request: mostly ordinary packet sizes, some full-range and edge sizes;
	// destinations split between on-subnet, anywhere, extremes and zero checksum.
	function automatic in_item_t random_request();
		in_item_t req;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			req.payload_bytes = 16'($urandom_range(0, 1500));
		else if (pick < 8)
			req.payload_bytes = 16'($urandom_range(0, 65535));
		else if (pick == 8)
			req.payload_bytes = 16'($urandom_range(65505, 65535));
		else
			case ($urandom_range(0, 3))
				0: req.payload_bytes = 16'd0;
				1: req.payload_bytes = 16'd65515;
				2: req.payload_bytes = 16'd65516;
				default: req.payload_bytes = 16'd65535;
			endcase
		req.protocol_number = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			req.destination_address = (own_addr & net_mask) | ($urandom & ~net_mask);
		else if (pick < 8)
			req.destination_address = $urandom;
		else if (pick == 8)
			req.destination_address = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		else
			req.destination_address = zero_cksum_dst(16'($urandom), req.protocol_number,
				req.payload_bytes);
		return req;
	endfunction

	// Receiver side: stall in bursts of random length while idling is on.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Watchdog: count cycles with no handshake and no register write.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = RegLocalAddr;
		cfg_data = 32'h0;
		in_valid = 1'b0;
		in_item = '0;
		idle_on = 1'b0;
		own_addr = 32'h0;
		net_mask = 32'h0;
		requests_sent = 0;
		settings_used = 1;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;

		// registers at reset: zero mask, so every destination is on-subnet
		send_request({32'h0A00_0001, 8'd6, 16'd0});
		send_request({32'hFFFF_FFFF, 8'hFF, 16'd65535});
		drain();

		// a typical /24 network: routing both ways, length edges, zero checksum
		apply_setting(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101);
		send_request({32'hC0A8_0114, 8'd17, 16'd100});
		send_request({32'h0808_0808, 8'd6, 16'd1480});
		send_request({32'hC0A8_01FF, 8'd0, 16'd0});
		send_request({32'hC0A8_0100, 8'd255, 16'd65515});
		send_request({32'h0A00_0001, 8'd1, 16'd65516});
		send_request({32'hC0A8_0105, 8'd6, 16'd65535});
		send_request({32'h0000_0000, 8'd17, 16'd20});
		send_request({32'hFFFF_FFFF, 8'd6, 16'd1});
		send_request({zero_cksum_dst(16'hC0A8, 8'd6, 16'd40), 8'd6, 16'd40});
		send_request({zero_cksum_dst(16'h0808, 8'd17, 16'd65535), 8'd17, 16'd65535});
		drain();

		// all ones everywhere; a stray write to the unused index must change nothing
		apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_reg(RegNone, 32'hDEAD_BEEF);
		send_request({32'hFFFF_FFFF, 8'hFF, 16'd65535});
		send_request({32'h0000_0000, 8'h00, 16'd0});
		send_request({32'hFFFF_FFFE, 8'h01, 16'd512});
		drain();

		// zero source with a host mask: only destination zero stays local
		apply_setting(32'h0000_0000, 32'hFFFF_FFFF, 32'h0A0A_0A0A);
		send_request({32'h0000_0000, 8'd6, 16'd0});
		send_request({32'h0000_0001, 8'd17, 16'd8});
		drain();

		// random phases, each under a fresh setting; the last one runs without idling
		for (int phase = 0; phase < RandomPhases; phase++) begin
			if (phase == RandomPhases - 1)
				idle_on = 1'b0;
			random_setting();
			repeat (PhaseItems) send_request(random_request());
			drain();
		end

		$display("Sent %0d requests under %0d register settings and checked %0d header words,",
			requests_sent, settings_used, words_checked);
		$display("covering both routing outcomes, length saturation and zero checksums.");
		if (mismatch_count == 0 && words_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
